// File: rtl/bbl_pkg.sv
// bbl_pkg: shared constants, beat types, slot table control/status structs
// and the free-byte helper for the byte-budget lru table
// depends on nothing
`timescale 1ns / 1ps
package bbl_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int RANK_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int LEN_W    = 24;
  localparam int USED_W   = LEN_W + $clog2(ENTRIES + 1);

  localparam logic [LEN_W-1:0] BUDGET_RESET = 24'd1049000;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_EVICT  = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_REJECT = 2'd3
  } result_kind_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_HIT_RD,
    S_EV_RD
  } state_t;

  typedef struct packed {
    logic        command;
    logic [63:0] key_tag;
    logic [23:0] object_length;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        hit;
    logic [63:0] key_out;
    logic [23:0] length_out;
    logic [23:0] free_bytes;
    logic [4:0]  entry_count;
    logic        last;
  } out_beat_t;

  // requests from the sequencer to the slot table
  typedef struct packed {
    logic                hit_upd;
    logic                ins;
    logic                evict;
    logic [IDX_W-1:0]    slot;
    logic [KEY_BITS-1:0] key;
  } slot_op_t;

  // search results of the slot table
  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    found;
    logic [IDX_W-1:0]    victim;
    logic [IDX_W-1:0]    free_slot;
    logic [CNT_W-1:0]    count;
    logic [KEY_BITS-1:0] slot_key;
  } slot_stat_t;

  // budget minus used bytes, saturating at zero
  function automatic logic [LEN_W-1:0] free_of(input logic [LEN_W-1:0] budget,
                                               input logic [USED_W-1:0] used);
    logic [USED_W-1:0] b;
    b = USED_W'(budget);
    if (b >= used) free_of = LEN_W'(b - used);
    else           free_of = '0;
  endfunction

endpackage

// File: rtl/byte_budget_lru_table.sv
// byte_budget_lru_table: sequencer, byte accounting and output register
// depends on bbl_pkg, bbl_len_ram, bbl_slot_table
//
//   channel | direction | handshake     | beat
//   in_     | input     | valid / stall | command, key_tag, object_length
//   out_    | output    | valid / stall | result fields, last marks the final beat
//   cfg_    | input     | valid / ready | budget_bytes (24 bits)
//
// a lookup miss is answered from the search state, a hit after a length ram read;
// an insert searches, then per eviction reads the victim length and searches again.
// in_stall is low only while the sequencer is idle; one item at a time.
// a stalled output holds the sequencer in its result state.
// synchronous active-low reset; no clearing pass, valid bits reset at once.
`timescale 1ns / 1ps
module byte_budget_lru_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbl_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bbl_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);
  import bbl_pkg::*;

  state_t              state_r, state_nxt;
  logic                cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    budget_r;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic [IDX_W-1:0]    rd_slot_r, rd_slot_nxt;
  logic                out_valid_r;
  out_beat_t           out_data_r, out_beat;
  logic                out_load;
  logic                out_free;

  slot_op_t            op;
  slot_stat_t          stat;
  logic                ram_we;
  logic [LEN_W-1:0]    ram_rdata;
  logic [LEN_W-1:0]    free_now;
  logic                too_big;
  logic                need_evict;
  logic                accept;

  bbl_slot_table u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .op_i   (op),
    .stat_o (stat)
  );

  // lengths live here; a slot is only read in a later cycle than its write
  bbl_len_ram #(.DEPTH(ENTRIES), .WIDTH(LEN_W)) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stat.free_slot),
    .wdata (len_r),
    .raddr (rd_slot_nxt),
    .rdata (ram_rdata)
  );

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // decisions on the current state
  assign free_now   = free_of(budget_r, used_r);
  assign too_big    = len_r > budget_r;
  assign need_evict = (free_now < len_r || stat.count >= CNT_W'(ENTRIES)) &&
                      (stat.count != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          if (cmd_r == CMD_LOOKUP) state_nxt = stat.hit ? S_HIT_RD : S_IDLE;
          else if (!too_big && need_evict) state_nxt = S_EV_RD;
          else state_nxt = S_IDLE;
        end
      end
      S_HIT_RD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_EV_RD: begin
        if (out_free) state_nxt = S_EVAL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    op          = '0;
    op.key      = key_r;
    op.slot     = rd_slot_r;
    ram_we      = 1'b0;
    rd_slot_nxt = rd_slot_r;
    used_nxt    = used_r;
    out_load    = 1'b0;
    out_beat             = '0;
    out_beat.free_bytes  = free_now;
    out_beat.entry_count = 5'(stat.count);
    out_beat.last        = 1'b1;
    case (state_r)
      S_EVAL: begin
        if (out_free) begin
          if (cmd_r == CMD_LOOKUP) begin
            if (stat.hit) begin
              op.hit_upd  = 1'b1;
              op.slot     = stat.found;
              rd_slot_nxt = stat.found;
            end else begin
              out_load             = 1'b1;
              out_beat.result_kind = KIND_LOOKUP;
            end
          end else if (too_big) begin
            out_load             = 1'b1;
            out_beat.result_kind = KIND_REJECT;
            out_beat.key_out     = 64'(key_r);
            out_beat.length_out  = len_r;
          end else if (need_evict) begin
            rd_slot_nxt = stat.victim;
          end else begin
            op.ins               = 1'b1;
            op.slot              = stat.free_slot;
            ram_we               = 1'b1;
            used_nxt             = used_r + USED_W'(len_r);
            out_load             = 1'b1;
            out_beat.result_kind = KIND_INSERT;
            out_beat.key_out     = 64'(key_r);
            out_beat.length_out  = len_r;
            out_beat.free_bytes  = free_of(budget_r, used_r + USED_W'(len_r));
            out_beat.entry_count = 5'(stat.count + CNT_W'(1));
          end
        end
      end
      S_HIT_RD: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_beat.result_kind = KIND_LOOKUP;
          out_beat.hit         = 1'b1;
          out_beat.key_out     = 64'(key_r);
          out_beat.length_out  = ram_rdata;
        end
      end
      S_EV_RD: begin
        if (out_free) begin
          op.evict             = 1'b1;
          used_nxt             = used_r - USED_W'(ram_rdata);
          out_load             = 1'b1;
          out_beat.result_kind = KIND_EVICT;
          out_beat.key_out     = 64'(stat.slot_key);
          out_beat.length_out  = ram_rdata;
          out_beat.free_bytes  = free_of(budget_r, used_r - USED_W'(ram_rdata));
          out_beat.entry_count = 5'(stat.count - CNT_W'(1));
          out_beat.last        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      budget_r    <= BUDGET_RESET;
      out_valid_r <= 1'b0;
      rd_slot_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_slot_r   <= rd_slot_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (cfg_valid && cfg_ready) budget_r <= cfg_data;
    end
  end

  // item capture and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key_tag[KEY_BITS-1:0];
      len_r <= in_data.object_length;
    end
    if (out_load) out_data_r <= out_beat;
  end

`ifndef NO_ASSERTIONS
  // stored count never exceeds the table size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  // an eviction is only started with a stored entry
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && state_nxt == S_EV_RD) |-> stat.count != '0)
    else $error("eviction with empty table");

  // an eviction beat is never the final beat and leaves the sequencer searching
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_beat.result_kind == KIND_EVICT) |=> state_r == S_EVAL)
    else $error("eviction beat not followed by a new search");
`endif

endmodule

// File: rtl/bbl_len_ram.sv
// bbl_len_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
module bbl_len_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bbl_slot_table.sv
// bbl_slot_table: slot keys, valid bits and age ranks with parallel search
// depends on bbl_pkg
`timescale 1ns / 1ps
module bbl_slot_table (
  input  logic                clk,
  input  logic                rst_n,
  input  bbl_pkg::slot_op_t   op_i,
  output bbl_pkg::slot_stat_t stat_o
);
  import bbl_pkg::*;

  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [RANK_W-1:0]   rank_r [ENTRIES];
  logic [RANK_W-1:0]   rank_nxt [ENTRIES];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KEY_BITS-1:0] key_mem [ENTRIES];

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  has_rank;
  logic [RANK_W-1:0]   best;
  logic [RANK_W-1:0]   sel_rank;

  // key compare on every slot, then lowest matching rank
  always_comb begin
    has_rank = '0;
    best     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_mem[i] == op_i.key);
    end
    for (int r = 0; r < ENTRIES; r++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i] && rank_r[i] == RANK_W'(r)) has_rank[r] = 1'b1;
      end
    end
    for (int r = ENTRIES - 1; r >= 0; r--) begin
      if (has_rank[r]) best = RANK_W'(r);
    end
  end

  // found, victim (oldest rank) and first free slot
  always_comb begin
    stat_o.hit       = |match;
    stat_o.found     = '0;
    stat_o.victim    = '0;
    stat_o.free_slot = '0;
    stat_o.count     = count_r;
    stat_o.slot_key  = key_mem[op_i.slot];
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i] && rank_r[i] == best) stat_o.found = IDX_W'(i);
      if (valid_r[i] && CNT_W'(rank_r[i]) == count_r - CNT_W'(1))
        stat_o.victim = IDX_W'(i);
      if (!valid_r[i]) stat_o.free_slot = IDX_W'(i);
    end
  end

  // rank, valid and count updates
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    sel_rank  = rank_r[op_i.slot];
    for (int i = 0; i < ENTRIES; i++) rank_nxt[i] = rank_r[i];
    if (op_i.hit_upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && rank_r[i] < sel_rank) rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
      rank_nxt[op_i.slot] = '0;
    end else if (op_i.ins) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i]) rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
      rank_nxt[op_i.slot]  = '0;
      valid_nxt[op_i.slot] = 1'b1;
      count_nxt            = count_r + CNT_W'(1);
    end else if (op_i.evict) begin
      valid_nxt[op_i.slot] = 1'b0;
      count_nxt            = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  // key store, written on insert only
  always_ff @(posedge clk) begin
    if (op_i.ins) key_mem[op_i.slot] <= op_i.key;
  end

endmodule

// File: sim/tb_byte_budget_lru_table.sv
// tb_byte_budget_lru_table: self-checking bench for the byte-budget lru table
// predicts every result beat from a behavioral copy of the table
// depends on bbl_pkg and rtl/byte_budget_lru_table.sv
`timescale 1ns / 1ps
module tb_byte_budget_lru_table;
  import bbl_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  byte_budget_lru_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow copy of the table
  logic [23:0] shadow_budget;
  logic        shadow_valid [NSLOT];
  logic [63:0] shadow_key   [NSLOT];
  logic [23:0] shadow_len   [NSLOT];
  int          shadow_rank  [NSLOT];
  logic [23:0] shadow_free;
  int          shadow_count;

  out_beat_t pending_beats[$];
  int        fail_count;
  int        beats_checked;
  int        items_sent;
  int        evictions_seen;
  int        idle_cycles;
  logic      out_gaps_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // recount used bytes and entries
  function automatic void refresh_free();
    longint used;
    int n;
    used = 0;
    n = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (shadow_valid[i]) begin
        used += shadow_len[i];
        n++;
      end
    end
    shadow_free = (shadow_budget >= used) ? 24'(shadow_budget - used) : 24'd0;
    shadow_count = n;
  endfunction

  function automatic void queue_beat(result_kind_t kind, logic hit, logic [63:0] key,
                                     logic [23:0] len, logic last);
    out_beat_t b;
    b.result_kind = kind;
    b.hit = hit;
    b.key_out = key;
    b.length_out = len;
    b.free_bytes = shadow_free;
    b.entry_count = 5'(shadow_count);
    b.last = last;
    pending_beats.push_back(b);
  endfunction

  // expected beats for one accepted item
  function automatic void predict_table(in_beat_t it);
    int found;
    int best;
    int victim;
    int worst;
    int free_slot;
    if (it.command == CMD_LOOKUP) begin
      found = -1;
      best = 0;
      for (int i = 0; i < NSLOT; i++)
        if (shadow_valid[i] && shadow_key[i] == it.key_tag &&
            (found < 0 || shadow_rank[i] < best)) begin
          found = i;
          best = shadow_rank[i];
        end
      if (found < 0) begin
        queue_beat(KIND_LOOKUP, 1'b0, 64'd0, 24'd0, 1'b1);
        return;
      end
      for (int i = 0; i < NSLOT; i++)
        if (shadow_valid[i] && shadow_rank[i] < best) shadow_rank[i]++;
      shadow_rank[found] = 0;
      queue_beat(KIND_LOOKUP, 1'b1, shadow_key[found], shadow_len[found], 1'b1);
      return;
    end
    if (it.object_length > shadow_budget) begin
      queue_beat(KIND_REJECT, 1'b0, it.key_tag, it.object_length, 1'b1);
      return;
    end
    while ((shadow_free < it.object_length || shadow_count >= NSLOT) && shadow_count > 0) begin
      victim = -1;
      worst = 0;
      for (int i = 0; i < NSLOT; i++)
        if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > worst)) begin
          victim = i;
          worst = shadow_rank[i];
        end
      shadow_valid[victim] = 1'b0;
      refresh_free();
      queue_beat(KIND_EVICT, 1'b0, shadow_key[victim], shadow_len[victim], 1'b0);
    end
    free_slot = -1;
    for (int i = NSLOT - 1; i >= 0; i--)
      if (!shadow_valid[i]) free_slot = i;
    if (free_slot >= 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (shadow_valid[i]) shadow_rank[i]++;
      shadow_valid[free_slot] = 1'b1;
      shadow_key[free_slot] = it.key_tag;
      shadow_len[free_slot] = it.object_length;
      shadow_rank[free_slot] = 0;
      refresh_free();
    end
    queue_beat(KIND_INSERT, 1'b0, it.key_tag, it.object_length, 1'b1);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid drops only when a gap follows
  task automatic send_item(logic cmd, logic [63:0] key, logic [23:0] len);
    in_beat_t it;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.command = cmd;
    it.key_tag = key;
    it.object_length = len;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table(it);
    items_sent++;
  endtask

  // sender idle while draining
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // budget write while idle
  task automatic write_budget(logic [23:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_budget = value;
    refresh_free();
  endtask

  // output side: random stall, checks every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat %p", $time, out_data);
        fail_count++;
      end else begin
        out_beat_t e;
        e = pending_beats.pop_front();
        beats_checked++;
        if (e.result_kind == KIND_EVICT) evictions_seen++;
        if (e !== out_data) begin
          $display("%0t mismatch expected %p actual %p", $time, e, out_data);
          fail_count++;
        end
      end
    end
    out_stall <= out_gaps_on && ($urandom_range(0, 99) < 30);
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // extremes, duplicates, miss, zero length, over budget
  task automatic test_directed();
    send_item(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
    send_item(CMD_INSERT, 64'd0, 24'd0);
    send_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 24'd1000);
    send_item(CMD_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 24'd2000);
    send_item(CMD_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 24'd3000);
    send_item(CMD_LOOKUP, 64'hA5A5_5A5A_0F0F_F0F0, 24'd0);
    send_item(CMD_LOOKUP, 64'd0, 24'd0);
    send_item(CMD_INSERT, 64'h1234, 24'hFFFFFF);
    send_item(CMD_LOOKUP, 64'h5555, 24'd7);
    send_item(CMD_INSERT, 64'h7777, 24'd1049000);
    send_item(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 24'd0);
  endtask

  // more than sixteen entries forces slot evictions
  task automatic test_slot_pressure();
    write_budget(24'hFFFFFF);
    send_item(CMD_INSERT, 64'h1, 24'hFFFFFF);
    for (int i = 0; i < 20; i++)
      send_item(CMD_INSERT, 64'(i + 16), 24'($urandom_range(0, 50)));
    send_item(CMD_LOOKUP, 64'd20, 24'd0);
  endtask

  // shrink budget under held entries, then zero budget
  task automatic test_budget_change();
    write_budget(24'd100);
    send_item(CMD_INSERT, 64'h99, 24'd60);
    send_item(CMD_INSERT, 64'h98, 24'd101);
    write_budget(24'd0);
    send_item(CMD_INSERT, 64'h97, 24'd0);
    send_item(CMD_INSERT, 64'h96, 24'd1);
  endtask

  // random traffic over a small key pool so lookups hit
  task automatic test_random(int n);
    logic [63:0] pool [8];
    int r;
    for (int i = 0; i < 8; i++) pool[i] = rand_key();
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) write_budget(24'd500);
      if (i == 2 * n / 3) write_budget(24'd5000);
      r = $urandom_range(0, 99);
      if (r < 45)
        send_item(CMD_LOOKUP, pool[$urandom_range(0, 7)], 24'($urandom()));
      else if (r < 85)
        send_item(CMD_INSERT, pool[$urandom_range(0, 7)], 24'($urandom_range(0, 900)));
      else if (r < 95)
        send_item(CMD_INSERT, rand_key(), 24'($urandom()));
      else
        send_item(CMD_LOOKUP, rand_key(), 24'($urandom()));
      // sender holds off once until everything has drained
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_gaps_on = 1'b0;
    fail_count = 0;
    beats_checked = 0;
    items_sent = 0;
    evictions_seen = 0;
    idle_cycles = 0;
    shadow_budget = BUDGET_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_len[i] = '0;
      shadow_rank[i] = 0;
    end
    refresh_free();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    out_gaps_on <= 1'b1;
    test_directed();
    test_slot_pressure();
    test_budget_change();
    test_random(140);
    wait_drained();
    $display("covered %0d items, %0d result beats, %0d evictions, budgets 0 to max",
             items_sent, beats_checked, evictions_seen);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bbl_pkg.sv
rtl/bbl_len_ram.sv
rtl/bbl_slot_table.sv
rtl/byte_budget_lru_table.sv
sim/tb_byte_budget_lru_table.sv
